@@ hw/rtl/dlnw_pkg.sv @@
package dlnw_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned DigitCount = 10;
  localparam int unsigned BcdWidth   = 4 * DigitCount;
  localparam int unsigned PadWidth   = 5;

  localparam logic [7:0] CMD_OPEN   = 8'h04;
  localparam logic [7:0] CMD_CLOSE  = 8'h06;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [PadWidth-1:0] MAX_PAD = 5'd16;

  localparam logic OP_SIGNED   = 1'b0;
  localparam logic OP_UNSIGNED = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_OPEN,
    S_DIGIT,
    S_ZERO,
    S_MINUS,
    S_SPACE,
    S_FILL,
    S_CLOSE
  } state_t;

endpackage

@@ hw/rtl/dlnw_bin2bcd.sv @@
// Serial binary to BCD converter (shift and add three), one bit per cycle.
module dlnw_bin2bcd
  import dlnw_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidth,
  parameter int unsigned DIGITS      = DigitCount
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic [VALUE_WIDTH-1:0]   mag,
  output logic                     done,
  output logic [4*DIGITS-1:0]      bcd
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH);
  localparam logic [CntWidth-1:0] LastCnt = CntWidth'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] shifter;
  logic [CntWidth-1:0]    cnt;
  logic                   running;
  logic [4*DIGITS-1:0]    bcd_adj;

  // Each digit of at least five gets three added before the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == LastCnt);
      if (load) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastCnt) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shifter <= mag;
      bcd     <= '0;
    end else if (running) begin
      shifter <= {shifter[VALUE_WIDTH-2:0], 1'b0};
      bcd     <= {bcd_adj[4*DIGITS-2:0], shifter[VALUE_WIDTH-1]};
    end
  end

endmodule

@@ hw/rtl/decimal_lcd_number_writer.sv @@
// Flow: an accepted start transaction runs a 32-step serial binary to BCD
// conversion, then the byte stream goes out one byte per cycle.
// The stream is 3 to 18 bytes long; a new start is not accepted until the
// closing byte of the previous stream has been strobed out.
// Reset: synchronous and active high; it returns the sequencer to idle and drops strobe.
// The receiver cannot stall: each byte is on the ports for exactly one strobed cycle.
module decimal_lcd_number_writer
  import dlnw_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidth,
  parameter int unsigned DIGITS      = DigitCount
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   op,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [PadWidth-1:0]    pad,
  input  logic [7:0]             fill_byte,
  output logic                   strobe,
  output logic [7:0]             out_byte,
  output logic                   is_command,
  output logic                   last
);

  localparam int unsigned BW = 4 * DIGITS;

  state_t state, state_next;

  // Item registers, captured when a start transaction is accepted.
  logic                op_r;
  logic                neg;
  logic                pad_nz;
  logic [PadWidth-1:0] pad_sat;
  logic [7:0]          fill;

  // Digit shift register and run counters.
  logic [BW-1:0]       digits, digits_next;
  logic                below_ten, below_ten_next;
  logic [PadWidth-1:0] count, count_next;
  logic [1:0]          spaces, spaces_next;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   conv_done;
  logic [BW-1:0]          bcd;

  logic                   emit;
  logic [7:0]             emit_byte;
  logic                   emit_cmd;
  logic                   emit_last;

  // Busy covers the last strobed cycle too, so no new transaction overlaps
  // the closing command.
  assign busy   = (state != S_IDLE) || strobe;
  assign accept = start && !busy;

  // In signed mode a negative value is negated modulo two to the width;
  // in unsigned mode only the low half of the word is converted.
  always_comb begin
    if (op == OP_UNSIGNED) begin
      mag = {{(VALUE_WIDTH/2){1'b0}}, value[VALUE_WIDTH/2-1:0]};
    end else if (value[VALUE_WIDTH-1]) begin
      mag = ~value + 1'b1;
    end else begin
      mag = value;
    end
  end

  dlnw_bin2bcd #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGITS      (DIGITS)
  ) u_bin2bcd (
    .clk  (clk),
    .rst  (rst),
    .load (accept),
    .mag  (mag),
    .done (conv_done),
    .bcd  (bcd)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op;
      neg     <= (op == OP_SIGNED) && value[VALUE_WIDTH-1];
      pad_nz  <= (pad != '0);
      pad_sat <= (pad > MAX_PAD) ? MAX_PAD : pad;
      fill    <= fill_byte;
    end
    digits    <= digits_next;
    below_ten <= below_ten_next;
    count     <= count_next;
    spaces    <= spaces_next;
  end

  // Sequencer: open command, digits least significant first, the mode's
  // suffix characters, and the closing command. One byte per cycle once the conversion is done.
  always_comb begin
    state_next     = state;
    digits_next    = digits;
    below_ten_next = below_ten;
    count_next     = count;
    spaces_next    = spaces;
    emit           = 1'b0;
    emit_byte      = CMD_OPEN;
    emit_cmd       = 1'b0;
    emit_last      = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          digits_next    = bcd;
          below_ten_next = (bcd[BW-1:4] == '0);
          count_next     = '0;
          spaces_next    = '0;
          state_next     = S_OPEN;
        end
      end
      S_OPEN: begin
        emit       = 1'b1;
        emit_byte  = CMD_OPEN;
        emit_cmd   = 1'b1;
        state_next = S_DIGIT;
      end
      S_DIGIT: begin
        emit        = 1'b1;
        emit_byte   = {4'h3, digits[3:0]};
        digits_next = {4'h0, digits[BW-1:4]};
        count_next  = count + 1'b1;
        // A zero magnitude still gives its single digit.
        if (digits[BW-1:4] == '0) begin
          if (op_r == OP_UNSIGNED) begin
            state_next = (count_next < pad_sat) ? S_FILL : S_CLOSE;
          end else if (below_ten) begin
            state_next = S_ZERO;
          end else if (neg) begin
            state_next = S_MINUS;
          end else if (pad_nz) begin
            state_next = S_SPACE;
          end else begin
            state_next = S_CLOSE;
          end
        end
      end
      S_ZERO: begin
        emit      = 1'b1;
        emit_byte = CHAR_ZERO;
        if (neg) begin
          state_next = S_MINUS;
        end else if (pad_nz) begin
          state_next = S_SPACE;
        end else begin
          state_next = S_CLOSE;
        end
      end
      S_MINUS: begin
        emit       = 1'b1;
        emit_byte  = CHAR_MINUS;
        state_next = pad_nz ? S_SPACE : S_CLOSE;
      end
      S_SPACE: begin
        emit        = 1'b1;
        emit_byte   = CHAR_SPACE;
        spaces_next = spaces + 1'b1;
        if (spaces == 2'd3) begin
          state_next = S_CLOSE;
        end
      end
      S_FILL: begin
        emit       = 1'b1;
        emit_byte  = fill;
        count_next = count + 1'b1;
        if (count_next >= pad_sat) begin
          state_next = S_CLOSE;
        end
      end
      S_CLOSE: begin
        emit       = 1'b1;
        emit_byte  = CMD_CLOSE;
        emit_cmd   = 1'b1;
        emit_last  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
    end
  end

  // Output payload registers follow the strobe.
  always_ff @(posedge clk) begin
    out_byte   <= emit_byte;
    is_command <= emit_cmd;
    last       <= emit_last;
  end

endmodule

@@ hw/rtl/dlnw_checker.sv @@
module dlnw_checker
  import dlnw_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [7:0] out_byte,
  input logic       is_command,
  input logic       last
);

  // An accepted transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // No byte is delivered while the block reports idle.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !strobe)
    else $error("strobe while not busy");

  // The closing byte is the close command.
  a_last_close: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> is_command && (out_byte == CMD_CLOSE))
    else $error("last byte is not the close command");

  // After the closing byte the block is free and silent.
  a_last_free: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !busy && !strobe)
    else $error("block still busy after closing byte");

endmodule

bind decimal_lcd_number_writer dlnw_checker u_dlnw_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .out_byte   (out_byte),
  .is_command (is_command),
  .last       (last)
);

@@ bench/tb_decimal_lcd_number_writer.sv @@
module tb_decimal_lcd_number_writer
  import dlnw_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // The run is cut off here if the block stops making progress. The limit
  // leaves a wide margin for about 470 numbers, even with the sender idling.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomCount = 446;
  localparam int unsigned TailCycles  = 80;
  localparam int unsigned ShownMax    = 10;

  // One number to be written, plus the chance (in percent) that the sender
  // stays idle on any cycle while this number is waiting to go out.
  typedef struct {
    logic                  op;
    logic [31:0]           value;
    logic [PadWidth-1:0]   pad;
    logic [7:0]            fill;
    int unsigned           idle_pct;
  } number_req_t;

  // One byte of the display stream as the block should present it.
  typedef struct packed {
    logic [7:0] ch;
    logic       cmd;
    logic       is_last;
  } lcd_byte_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                op = OP_SIGNED;
  logic [31:0]         value = '0;
  logic [PadWidth-1:0] pad = '0;
  logic [7:0]          fill_byte = '0;
  logic                strobe;
  logic [7:0]          out_byte;
  logic                is_command;
  logic                last;

  number_req_t numbers_pending[$];
  lcd_byte_t   stream_due[$];
  lcd_byte_t   byte_want;

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_checked = 0;
  int unsigned signed_numbers = 0;
  int unsigned unsigned_numbers = 0;
  int unsigned negative_numbers = 0;
  int unsigned wide_pad_numbers = 0;
  bit          timed_out = 1'b0;

  decimal_lcd_number_writer DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .value      (value),
    .pad        (pad),
    .fill_byte  (fill_byte),
    .strobe     (strobe),
    .out_byte   (out_byte),
    .is_command (is_command),
    .last       (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Predictor. Appends the full byte stream for one number to the queue of
  // bytes the display should receive. The digits go out least significant
  // first because the display cursor runs right to left during the stream.
  function automatic void queue_number_stream(input number_req_t req);
    logic [31:0] mag;
    logic [31:0] rest;
    logic        neg;
    int unsigned digit_total;
    int unsigned width;
    stream_due.push_back('{ch: CMD_OPEN, cmd: 1'b1, is_last: 1'b0});
    if (req.op == OP_SIGNED) begin
      neg = req.value[31];
      mag = neg ? (~req.value + 32'd1) : req.value;
    end else begin
      neg = 1'b0;
      mag = {16'h0000, req.value[15:0]};
    end
    // Zero still produces one digit, so the loop body always runs once.
    rest = mag;
    digit_total = 0;
    do begin
      stream_due.push_back('{ch: CHAR_ZERO + 8'(rest % 32'd10), cmd: 1'b0, is_last: 1'b0});
      rest = rest / 32'd10;
      digit_total++;
    end while (rest != 32'd0);
    if (req.op == OP_SIGNED) begin
      // Signed numbers always show at least two digits, then the sign,
      // then a fixed block of four blanks when any padding is requested.
      if (mag < 32'd10)
        stream_due.push_back('{ch: CHAR_ZERO, cmd: 1'b0, is_last: 1'b0});
      if (neg)
        stream_due.push_back('{ch: CHAR_MINUS, cmd: 1'b0, is_last: 1'b0});
      if (req.pad != '0)
        repeat (4) stream_due.push_back('{ch: CHAR_SPACE, cmd: 1'b0, is_last: 1'b0});
    end else begin
      // Unsigned numbers are filled out to the requested width, which never
      // goes beyond sixteen characters.
      width = 32'((req.pad > MAX_PAD) ? MAX_PAD : req.pad);
      while (digit_total < width) begin
        stream_due.push_back('{ch: req.fill, cmd: 1'b0, is_last: 1'b0});
        digit_total++;
      end
    end
    stream_due.push_back('{ch: CMD_CLOSE, cmd: 1'b1, is_last: 1'b1});
  endfunction

  task automatic add_number(input logic num_op, input logic [31:0] num_value,
                            input logic [PadWidth-1:0] num_pad, input logic [7:0] num_fill,
                            input int unsigned idle_pct);
    number_req_t req;
    req.op = num_op;
    req.value = num_value;
    req.pad = num_pad;
    req.fill = num_fill;
    req.idle_pct = idle_pct;
    numbers_pending.push_back(req);
  endtask

  // Random values lean toward the interesting corners: single digits (the
  // extra leading zero), negative numbers, powers of ten on either side of
  // a new digit, the 32-bit extremes, and unsigned values whose upper half
  // must be ignored.
  function automatic logic [31:0] pick_value();
    logic [31:0] tens;
    logic [31:0] picked;
    int unsigned k;
    tens = 32'd1;
    k = $urandom_range(0, 9);
    repeat (k) tens = tens * 32'd10;
    case ($urandom_range(0, 6))
      0, 1: picked = $urandom;
      2: picked = $urandom_range(0, 20);
      3: picked = -$urandom_range(1, 20);
      4: picked = tens + $urandom_range(0, 2) - 32'd1;
      5: begin
        case ($urandom_range(0, 3))
          0: picked = 32'h8000_0000;
          1: picked = 32'h7FFF_FFFF;
          2: picked = 32'hFFFF_FFFF;
          default: picked = 32'h8000_0001;
        endcase
      end
      default: picked = {16'($urandom), 16'($urandom_range(0, 2) == 0 ? 16'hFFFF :
                                              16'($urandom_range(0, 999)))};
    endcase
    if ($urandom_range(0, 3) == 0 && picked != 32'h8000_0000)
      picked = -picked;
    return picked;
  endfunction

  // Sender. A number stays offered until the block takes it; once taken, the
  // next one may follow on the very next cycle unless the sender idles.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        queue_number_stream(numbers_pending[0]);
        if (numbers_pending[0].op == OP_SIGNED) begin
          signed_numbers++;
          if (numbers_pending[0].value[31]) negative_numbers++;
        end else begin
          unsigned_numbers++;
          if (numbers_pending[0].pad > MAX_PAD) wide_pad_numbers++;
        end
        void'(numbers_pending.pop_front());
      end
      if (!(start && busy)) begin
        if (numbers_pending.size() != 0 &&
            $urandom_range(0, 99) >= numbers_pending[0].idle_pct) begin
          start     <= 1'b1;
          op        <= numbers_pending[0].op;
          value     <= numbers_pending[0].value;
          pad       <= numbers_pending[0].pad;
          fill_byte <= numbers_pending[0].fill;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Receiver. The block cannot be held off, so every strobed cycle is taken
  // at the edge that ends it and checked against the oldest byte due.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (stream_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ShownMax)
          $display("[%0t] unexpected byte: out_byte=%02h is_command=%0b last=%0b",
                   $realtime, out_byte, is_command, last);
      end else begin
        byte_want = stream_due.pop_front();
        bytes_checked++;
        if (out_byte !== byte_want.ch || is_command !== byte_want.cmd ||
            last !== byte_want.is_last) begin
          mismatch_count++;
          if (mismatch_count <= ShownMax)
            $display("[%0t] byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     $realtime, byte_want.ch, byte_want.cmd, byte_want.is_last,
                     out_byte, is_command, last);
        end
      end
    end
  end

  initial begin
    int unsigned phase_pct[3];
    // The receiver cannot stall, so the phases only vary the sender: none,
    // heavy idling, then light idling.
    phase_pct[0] = 0;
    phase_pct[1] = 74;
    phase_pct[2] = 31;

    // Directed numbers: zero and single digits, digit-count boundaries, the
    // most negative value, all-ones patterns, padding past its ceiling, and
    // unsigned values whose upper half must be dropped.
    add_number(OP_SIGNED,   32'd0,          5'd0,  8'h00, 0);
    add_number(OP_SIGNED,   32'd7,          5'd1,  8'hFF, 0);
    add_number(OP_SIGNED,   32'd9,          5'd0,  8'h00, 0);
    add_number(OP_SIGNED,   32'd10,         5'd16, 8'h00, 0);
    add_number(OP_SIGNED,   32'hFFFF_FFFF,  5'd5,  8'hAA, 0);
    add_number(OP_SIGNED,   -32'd9,         5'd0,  8'h55, 0);
    add_number(OP_SIGNED,   -32'd10,        5'd31, 8'h00, 0);
    add_number(OP_SIGNED,   32'h8000_0000,  5'd16, 8'hFF, 0);
    add_number(OP_SIGNED,   32'h7FFF_FFFF,  5'd31, 8'h00, 0);
    add_number(OP_SIGNED,   32'd1000000000, 5'd0,  8'h00, 0);
    add_number(OP_SIGNED,   32'h8000_0001,  5'd10, 8'h2A, 0);
    add_number(OP_UNSIGNED, 32'd0,          5'd0,  8'h2A, 0);
    add_number(OP_UNSIGNED, 32'd0,          5'd16, 8'hFF, 0);
    add_number(OP_UNSIGNED, 32'h0000_FFFF,  5'd16, 8'h20, 0);
    add_number(OP_UNSIGNED, 32'd5,          5'd16, 8'hFF, 0);
    add_number(OP_UNSIGNED, 32'd12345,      5'd31, 8'h00, 0);
    add_number(OP_UNSIGNED, 32'hABCD_0000,  5'd3,  8'h2A, 0);
    add_number(OP_UNSIGNED, 32'h1234_FFFF,  5'd17, 8'h30, 0);
    add_number(OP_UNSIGNED, 32'd9,          5'd1,  8'hAA, 0);
    add_number(OP_UNSIGNED, 32'd10,         5'd2,  8'h55, 0);
    add_number(OP_UNSIGNED, 32'hFFFF_FFFF,  5'd4,  8'h5F, 0);
    add_number(OP_UNSIGNED, 32'd65535,      5'd6,  8'h01, 0);
    add_number(OP_SIGNED,   32'hFFFF_0000,  5'd1,  8'h00, 0);
    add_number(OP_UNSIGNED, 32'd100,        5'd15, 8'h80, 0);

    for (int unsigned n = 0; n < RandomCount; n++) begin
      add_number(1'($urandom_range(0, 1)), pick_value(),
                 ($urandom_range(0, 4) == 0) ? 5'($urandom_range(17, 31)) :
                                               5'($urandom_range(0, 16)),
                 8'($urandom), phase_pct[n * 3 / RandomCount]);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait for every number to be taken and every byte to be seen.
    while ((numbers_pending.size() != 0 || start || stream_due.size() != 0) &&
           cycle_count < CycleLimit)
      @(posedge clk);
    timed_out = (cycle_count >= CycleLimit);

    // Give a stray trailing byte the chance to show up.
    if (!timed_out)
      repeat (TailCycles) @(posedge clk);

    if (stream_due.size() != 0) begin
      $display("%0d display bytes never arrived", stream_due.size());
      mismatch_count += stream_due.size();
    end
    if (timed_out)
      $display("run stopped after %0d cycles without finishing", cycle_count);

    $display("Wrote %0d signed numbers (%0d negative) and %0d unsigned numbers (%0d padded past 16),",
             signed_numbers, negative_numbers, unsigned_numbers, wide_pad_numbers);
    $display("checking %0d display bytes in %0d cycles; %0d mismatches.",
             bytes_checked, cycle_count, mismatch_count);

    if (mismatch_count == 0 && !timed_out)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
